>>> hdl/julian_day_to_calendar_unit_defines.svh
// Assertion macros shared by the Julian date converter RTL.
`ifndef JULIAN_DAY_TO_CALENDAR_UNIT_DEFINES_SVH
`define JULIAN_DAY_TO_CALENDAR_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdc assertion failed: same-cycle implication");

// Checks that the consequent holds in the cycle after the antecedent.
`define JDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdc assertion failed: next-cycle implication");

`endif

>>> hdl/jdc_pkg.sv
// Shared constants, tables and types of the Julian date converter.
`default_nettype none

package jdc_pkg;

    localparam int FRAC_BITS = 32;
    localparam int DAY_BITS  = 22;
    localparam int IN_BITS   = DAY_BITS + FRAC_BITS;

    localparam logic [IN_BITS-1:0] HALF_DAY = IN_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [IN_BITS-1:0] LOW_LIMIT =
        (IN_BITS'(2415079) << FRAC_BITS) + HALF_DAY;
    localparam logic [IN_BITS-1:0] HIGH_LIMIT =
        (IN_BITS'(2488128) << FRAC_BITS) + ((IN_BITS'(49) << FRAC_BITS) / 100);

    // Across the whole window the century correction nets out to a fixed offset.
    localparam logic [DAY_BITS-1:0] C_OFFSET = DAY_BITS'(1537);

    localparam int N_BITS = 27;
    localparam logic [N_BITS-1:0] N_OFFSET = N_BITS'(28298);

    localparam int Q_BITS      = 15;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_BITS  = 20;
    localparam int PROD_BITS   = N_BITS + RECIP_BITS;
    localparam logic [N_BITS-1:0] YEAR_DIV = N_BITS'(7305);
    localparam logic [RECIP_BITS-1:0] YEAR_RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / 7305);

    localparam int E_BITS = 24;
    localparam logic [E_BITS-1:0] DAYS_PER_YEAR = E_BITS'(365);

    localparam int G_BITS = 10;
    localparam int F_BITS = 5;
    localparam int F_MAX  = 16;
    localparam logic [F_BITS-1:0] F_JANUARY = F_BITS'(14);
    localparam logic [F_BITS-1:0] F_YEAR_WRAP = F_BITS'(13);
    localparam logic [3:0] MONTH_MARCH = 4'd3;
    localparam logic [Q_BITS-1:0] YEAR_OFFSET = Q_BITS'(4715);

    // Floor of 30.6001 times the month index.
    localparam logic [G_BITS-1:0] MONTH_FLOOR [0:F_MAX] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153,
        10'd183, 10'd214, 10'd244, 10'd275, 10'd306, 10'd336,
        10'd367, 10'd397, 10'd428, 10'd459, 10'd489
    };

    // Ceiling of 30.6001 times the month index.
    localparam logic [G_BITS-1:0] MONTH_CEIL [1:F_MAX] = '{
        10'd31,  10'd62,  10'd92,  10'd123, 10'd154, 10'd184,
        10'd215, 10'd245, 10'd276, 10'd307, 10'd337, 10'd368,
        10'd398, 10'd429, 10'd460, 10'd490
    };

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } tod_adv_t;

endpackage

`default_nettype wire

>>> hdl/jdc_tod.sv
// Time-of-day pipeline: splits the day fraction into hour, minute and second.
`default_nettype none

module jdc_tod (
    input  logic                            clk,
    input  jdc_pkg::tod_adv_t               adv,
    input  logic [jdc_pkg::FRAC_BITS-1:0]   frac,
    output logic [4:0]                      hour,
    output logic [5:0]                      minute,
    output logic [5:0]                      second
);
    import jdc_pkg::*;

    localparam int HP_W = FRAC_BITS + 5;
    localparam int MP_W = FRAC_BITS + 6;

    logic [HP_W-1:0]      hour_prod;
    logic [MP_W-1:0]      min_prod;
    logic [MP_W-1:0]      sec_prod;
    logic [4:0]           hour_s2_reg;
    logic [4:0]           hour_s3_reg;
    logic [4:0]           hour_s4_reg;
    logic [5:0]           minute_s3_reg;
    logic [5:0]           minute_s4_reg;
    logic [5:0]           second_s4_reg;
    logic [FRAC_BITS-1:0] rem_h_reg;
    logic [FRAC_BITS-1:0] rem_m_reg;

    always_comb
    begin
        hour_prod = HP_W'(frac) * HP_W'(24);
        min_prod  = MP_W'(rem_h_reg) * MP_W'(60);
        sec_prod  = MP_W'(rem_m_reg) * MP_W'(60);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            hour_s2_reg <= hour_prod[FRAC_BITS +: 5];
            rem_h_reg   <= hour_prod[FRAC_BITS-1:0];
        end
        if (adv.s3)
        begin
            hour_s3_reg   <= hour_s2_reg;
            minute_s3_reg <= min_prod[FRAC_BITS +: 6];
            rem_m_reg     <= min_prod[FRAC_BITS-1:0];
        end
        if (adv.s4)
        begin
            hour_s4_reg   <= hour_s3_reg;
            minute_s4_reg <= minute_s3_reg;
            second_s4_reg <= sec_prod[FRAC_BITS +: 6];
        end
    end

    assign hour   = hour_s4_reg;
    assign minute = minute_s4_reg;
    assign second = second_s4_reg;

endmodule

`default_nettype wire

>>> hdl/julian_day_to_calendar_unit.sv
// Julian date to Gregorian date and time-of-day converter, top level.
//
// The converter takes one Julian date per cycle while out_stall is low and passes it through
// a seven-stage pipeline that includes the output register; the stages hold the range check,
// the century correction, a reciprocal multiply and a correction for the year count, the
// day-of-year subtraction, the month search and the final assembly, with the time of day
// split alongside. Each stage advances whenever the stage after it is empty or moving, so
// bubbles close up and a stall on the output holds all items in place.
// Dates outside 2415079.5 to 2488128.49 return out_of_range set and all other fields zero.
`default_nettype none
`include "julian_day_to_calendar_unit_defines.svh"

module julian_day_to_calendar_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [jdc_pkg::IN_BITS-1:0]   julian_date,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          out_of_range,
    output logic [11:0]                   year,
    output logic [3:0]                    month,
    output logic [4:0]                    day_of_month,
    output logic [4:0]                    hour,
    output logic [5:0]                    minute,
    output logic [5:0]                    second
);
    import jdc_pkg::*;

    logic en1, en2, en3, en4, en5, en6, en7;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    tod_adv_t tod_adv;

    logic                 oor1_next;
    logic [IN_BITS-1:0]   shifted;
    logic                 oor1_reg;
    logic [DAY_BITS-1:0]  a1_reg;
    logic [FRAC_BITS-1:0] frac1_reg;

    logic [DAY_BITS-1:0]  c2_next;
    logic [N_BITS-1:0]    n2_next;
    logic                 oor2_reg;
    logic [DAY_BITS-1:0]  c2_reg;
    logic [N_BITS-1:0]    n2_reg;

    logic [PROD_BITS-1:0] q_prod;
    logic                 oor3_reg;
    logic [DAY_BITS-1:0]  c3_reg;
    logic [N_BITS-1:0]    n3_reg;
    logic [Q_BITS-1:0]    q3_reg;

    logic [N_BITS-1:0]    q_rem;
    logic [Q_BITS-1:0]    d4_next;
    logic                 oor4_reg;
    logic [DAY_BITS-1:0]  c4_reg;
    logic [Q_BITS-1:0]    d4_reg;

    logic [E_BITS-1:0]    e_days;
    logic [E_BITS-1:0]    g_full;
    logic [4:0]           hour4;
    logic [5:0]           minute4;
    logic [5:0]           second4;
    logic                 oor5_reg;
    logic [Q_BITS-1:0]    d5_reg;
    logic [G_BITS-1:0]    g5_reg;
    logic [4:0]           hour5_reg;
    logic [5:0]           minute5_reg;
    logic [5:0]           second5_reg;

    logic [F_BITS-1:0]    f6_next;
    logic                 oor6_reg;
    logic [Q_BITS-1:0]    d6_reg;
    logic [G_BITS-1:0]    g6_reg;
    logic [F_BITS-1:0]    f6_reg;
    logic [4:0]           hour6_reg;
    logic [5:0]           minute6_reg;
    logic [5:0]           second6_reg;

    logic [G_BITS-1:0]    day_full;
    logic [F_BITS-1:0]    month_full;
    logic [3:0]           month7_next;
    logic [Q_BITS-1:0]    year_full;
    logic                 oor7_reg;
    logic [11:0]          year7_reg;
    logic [3:0]           month7_reg;
    logic [4:0]           day7_reg;
    logic [4:0]           hour7_reg;
    logic [5:0]           minute7_reg;
    logic [5:0]           second7_reg;

    logic                 oor_fields_zero;
    logic                 fields_in_range;

    always_comb
    begin
        en7 = !v7_reg || !out_stall;
        en6 = !v6_reg || en7;
        en5 = !v5_reg || en6;
        en4 = !v4_reg || en5;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
        tod_adv.s2 = en2;
        tod_adv.s3 = en3;
        tod_adv.s4 = en4;
    end

    assign in_stall  = !en1;
    assign out_valid = v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        oor1_next = (julian_date < LOW_LIMIT) || (julian_date > HIGH_LIMIT);
        shifted   = julian_date + HALF_DAY;

        c2_next = a1_reg + C_OFFSET;
        n2_next = (N_BITS'(a1_reg) << 4) + (N_BITS'(a1_reg) << 2) + N_OFFSET;

        q_prod = PROD_BITS'(n2_reg) * PROD_BITS'(YEAR_RECIP);

        q_rem   = n3_reg - N_BITS'(q3_reg) * YEAR_DIV;
        d4_next = q3_reg + Q_BITS'(q_rem >= YEAR_DIV);

        e_days = E_BITS'(d4_reg) * DAYS_PER_YEAR + E_BITS'(d4_reg >> 2);
        g_full = E_BITS'(c4_reg) - e_days;

        f6_next = '0;
        for (int k = 1; k <= F_MAX; k++)
        begin
            f6_next = f6_next + F_BITS'(g5_reg >= MONTH_CEIL[k]);
        end

        day_full    = g6_reg - MONTH_FLOOR[f6_reg];
        month_full  = (f6_reg >= F_JANUARY) ? f6_reg - F_YEAR_WRAP : f6_reg - F_BITS'(1);
        month7_next = month_full[3:0];
        year_full   = d6_reg - YEAR_OFFSET - Q_BITS'(month7_next >= MONTH_MARCH);
    end

    jdc_tod u_tod (
        .clk    (clk),
        .adv    (tod_adv),
        .frac   (frac1_reg),
        .hour   (hour4),
        .minute (minute4),
        .second (second4)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            oor1_reg  <= oor1_next;
            a1_reg    <= shifted[IN_BITS-1:FRAC_BITS];
            frac1_reg <= shifted[FRAC_BITS-1:0];
        end
        if (en2)
        begin
            oor2_reg <= oor1_reg;
            c2_reg   <= c2_next;
            n2_reg   <= n2_next;
        end
        if (en3)
        begin
            oor3_reg <= oor2_reg;
            c3_reg   <= c2_reg;
            n3_reg   <= n2_reg;
            q3_reg   <= q_prod[RECIP_SHIFT +: Q_BITS];
        end
        if (en4)
        begin
            oor4_reg <= oor3_reg;
            c4_reg   <= c3_reg;
            d4_reg   <= d4_next;
        end
        if (en5)
        begin
            oor5_reg    <= oor4_reg;
            d5_reg      <= d4_reg;
            g5_reg      <= g_full[G_BITS-1:0];
            hour5_reg   <= hour4;
            minute5_reg <= minute4;
            second5_reg <= second4;
        end
        if (en6)
        begin
            oor6_reg    <= oor5_reg;
            d6_reg      <= d5_reg;
            g6_reg      <= g5_reg;
            f6_reg      <= f6_next;
            hour6_reg   <= hour5_reg;
            minute6_reg <= minute5_reg;
            second6_reg <= second5_reg;
        end
        if (en7)
        begin
            oor7_reg    <= oor6_reg;
            year7_reg   <= oor6_reg ? '0 : year_full[11:0];
            month7_reg  <= oor6_reg ? '0 : month7_next;
            day7_reg    <= oor6_reg ? '0 : day_full[4:0];
            hour7_reg   <= oor6_reg ? '0 : hour6_reg;
            minute7_reg <= oor6_reg ? '0 : minute6_reg;
            second7_reg <= oor6_reg ? '0 : second6_reg;
        end
    end

    assign out_of_range = oor7_reg;
    assign year         = year7_reg;
    assign month        = month7_reg;
    assign day_of_month = day7_reg;
    assign hour         = hour7_reg;
    assign minute       = minute7_reg;
    assign second       = second7_reg;

    assign oor_fields_zero = year == '0 && month == '0 && day_of_month == '0
                             && hour == '0 && minute == '0 && second == '0;
    assign fields_in_range = month >= 4'd1 && month <= 4'd12 && day_of_month != '0
                             && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59;

    `JDC_ASSERT_NOW(a_oor_fields_zero, out_valid && out_of_range, oor_fields_zero)
    `JDC_ASSERT_NOW(a_fields_sane, out_valid && !out_of_range, fields_in_range)
    `JDC_ASSERT_NOW(a_flow_through, !out_stall, !in_stall)

endmodule

`default_nettype wire

>>> sim/julian_day_to_calendar_unit_tb.sv
// Testbench for the Julian date to Gregorian calendar converter.
`timescale 1ns / 1ps

module julian_day_to_calendar_unit_tb;

    localparam int IN_W = jdc_pkg::IN_BITS;
    localparam int FRAC_W = jdc_pkg::FRAC_BITS;

    localparam longint unsigned HALF = 64'd1 << (FRAC_W - 1);
    localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_W) - 1;
    localparam longint unsigned WINDOW_LOW = (64'd2415079 << FRAC_W) + HALF;
    localparam longint unsigned WINDOW_HIGH =
        (64'd2488128 << FRAC_W) + ((64'd49 << FRAC_W) / 100);

    localparam int RANDOM_DATES = 1730;
    localparam int IDLE_PERCENT = 37;
    localparam int QUIET_FROM = 600;
    localparam int QUIET_TO = 900;
    localparam int HOLD_AT = 1200;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic        out_of_range;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    typedef struct packed {
        logic [IN_W-1:0] jd;
        logic            typed;
        calendar_t       cal;
    } date_case_t;

    localparam calendar_t OUT_OF_WINDOW = '{1'b1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [IN_W-1:0] julian_date;
    logic            out_valid;
    logic            out_stall;
    logic            out_of_range;
    logic [11:0]     year;
    logic [3:0]      month;
    logic [4:0]      day_of_month;
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;

    calendar_t expected_dates[$];
    int dates_sent = 0;
    int results_checked = 0;
    int in_window_seen = 0;
    int out_window_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    julian_day_to_calendar_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .julian_date  (julian_date),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_of_range (out_of_range),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

    always #6 clk = ~clk;

    function automatic calendar_t predict_calendar(input logic [IN_W-1:0] jd);
        calendar_t res;
        longint unsigned v, shifted, a, b, c, d, e, g, f, mon, frac, secs;
        res = '0;
        v = 64'(jd);
        if (v < WINDOW_LOW || v > WINDOW_HIGH)
        begin
            res.out_of_range = 1'b1;
            return res;
        end
        shifted = v + HALF;
        a = shifted >> FRAC_W;
        frac = shifted & FRAC_MASK;
        b = (4 * a - 7468865) / 146097;
        c = a + b - b / 4 + 1525;
        d = (20 * c - 2442) / 7305;
        e = 365 * d + d / 4;
        g = c - e;
        f = (g * 10000) / 306001;
        mon = f - 1 - 12 * (f / 14);
        secs = (frac * 86400) >> FRAC_W;
        res.year = 12'(d - 4715 - (7 + mon) / 10);
        res.month = 4'(mon);
        res.day_of_month = 5'(g - (306001 * f) / 10000);
        res.hour = 5'(secs / 3600);
        res.minute = 6'((secs / 60) % 60);
        res.second = 6'(secs % 60);
        return res;
    endfunction

    function automatic logic [IN_W-1:0] day_point(input longint unsigned day_num,
                                                  input longint unsigned day_frac);
        return IN_W'((day_num << FRAC_W) + day_frac);
    endfunction

    task automatic send_date(input logic [IN_W-1:0] jd, input logic typed,
                             input calendar_t fixed);
        while (!(dates_sent >= QUIET_FROM && dates_sent < QUIET_TO)
               && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        julian_date <= jd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_dates.push_back(typed ? fixed : predict_calendar(jd));
        dates_sent++;
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        calendar_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result transfer, expected none, actual year %0d",
                         $time, year);
            end
            else
            begin
                want = expected_dates.pop_front();
                compare_field("out_of_range", want.out_of_range, out_of_range);
                compare_field("year", want.year, year);
                compare_field("month", want.month, month);
                compare_field("day_of_month", want.day_of_month, day_of_month);
                compare_field("hour", want.hour, hour);
                compare_field("minute", want.minute, minute);
                compare_field("second", want.second, second);
                results_checked++;
                if (want.out_of_range)
                    out_window_seen++;
                else
                    in_window_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles without a transfer", quiet_cycles);
        $display("julian_day_to_calendar_unit test failed");
        $finish;
    end

    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_checked >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (results_checked >= QUIET_FROM && results_checked < QUIET_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial
    begin
        date_case_t cases[$];
        longint unsigned pick;
        logic [IN_W-1:0] jd;
        int n;
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        julian_date = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        cases.push_back('{IN_W'(0), 1'b1, OUT_OF_WINDOW});
        cases.push_back('{{IN_W{1'b1}}, 1'b1, OUT_OF_WINDOW});
        cases.push_back('{IN_W'(WINDOW_LOW - 1), 1'b1, OUT_OF_WINDOW});
        cases.push_back('{IN_W'(WINDOW_LOW), 1'b1,
                          '{1'b0, 12'd1900, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}});
        cases.push_back('{IN_W'(WINDOW_HIGH), 1'b1,
                          '{1'b0, 12'd2100, 4'd2, 5'd28, 5'd23, 6'd45, 6'd35}});
        cases.push_back('{IN_W'(WINDOW_HIGH + 1), 1'b1, OUT_OF_WINDOW});
        cases.push_back('{day_point(2415080, HALF - 1), 1'b0, '0});
        cases.push_back('{day_point(2415384, HALF), 1'b0, '0});
        cases.push_back('{day_point(2415385, HALF - 1), 1'b0, '0});
        cases.push_back('{day_point(2415385, HALF), 1'b0, '0});
        cases.push_back('{day_point(2451544, HALF - 1), 1'b0, '0});
        cases.push_back('{day_point(2451544, HALF), 1'b0, '0});
        cases.push_back('{day_point(2451545, 0), 1'b0, '0});
        cases.push_back('{day_point(2451545, HALF + 1), 1'b0, '0});
        cases.push_back('{day_point(2451603, HALF), 1'b0, '0});
        cases.push_back('{day_point(2451604, HALF - 1), 1'b0, '0});
        cases.push_back('{day_point(2451604, HALF), 1'b0, '0});
        cases.push_back('{day_point(2453064, HALF), 1'b0, '0});
        cases.push_back('{day_point(2486667, HALF), 1'b0, '0});
        cases.push_back('{day_point(2488069, HALF - 1), 1'b0, '0});
        cases.push_back('{day_point(2488069, HALF), 1'b0, '0});
        foreach (cases[i])
            send_date(cases[i].jd, cases[i].typed, cases[i].cal);

        for (n = 0; n < RANDOM_DATES; n++)
        begin
            kind = $urandom_range(99);
            pick = {$urandom, $urandom};
            if (kind < 60)
                jd = IN_W'(WINDOW_LOW + pick % (WINDOW_HIGH - WINDOW_LOW + 1));
            else if (kind < 75)
                jd = day_point($urandom_range(2488127, 2415080),
                               HALF - 2 + $urandom_range(3));
            else if (kind < 85)
                jd = IN_W'(($urandom_range(1) ? WINDOW_LOW : WINDOW_HIGH)
                           + $urandom_range(6) - 3);
            else
                jd = IN_W'(pick);
            send_date(jd, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d dates: %0d inside the 1900-2100 window, %0d flagged out of range.",
                 results_checked, in_window_seen, out_window_seen);
        $display("Traffic mixed random idles, an idle-free stretch and a long output hold.");
        if (mismatches == 0 && expected_dates.size() == 0)
            $display("julian_day_to_calendar_unit test passed");
        else
            $display("julian_day_to_calendar_unit test failed");
        $finish;
    end

endmodule
